>>> design/psd_pkg.sv
// shared constants and codes for the primitive signed distance block
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [1:0] {
    SHAPE_SPHERE = 2'd0,
    SHAPE_BOX    = 2'd1,
    SHAPE_CYL    = 2'd2
  } shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE  = 3'd0,
    REG_RADIUS = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_BOX_X  = 3'd3,
    REG_BOX_Y  = 3'd4,
    REG_BOX_Z  = 3'd5
  } reg_idx_e;

endpackage

>>> design/psd_if.sv
// point and distance stream interfaces
interface psd_in_if import psd_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface psd_out_if import psd_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] distance;
  logic        [1:0]    faces_outside;

  modport source (output valid, distance, faces_outside, input ready);
  modport sink   (input valid, distance, faces_outside, output ready);
endinterface

>>> design/psd_sqrt.sv
// pipelined integer floor square root, one result bit per stage
module psd_sqrt #(
  parameter int IN_W = 66,
  parameter int SB_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SB_W-1:0]     sb_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SB_W-1:0]     sb_o
);

  localparam int NST   = IN_W / 2;
  localparam int RT_W  = NST;
  localparam int REM_W = RT_W + 2;

  logic              v_q    [NST];
  logic [IN_W-1:0]   rad_q  [NST];
  logic [REM_W-1:0]  rem_q  [NST];
  logic [RT_W-1:0]   root_q [NST];
  logic [SB_W-1:0]   sb_q   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic             v_in;
    logic [IN_W-1:0]  rad_in;
    logic [REM_W-1:0] rem_in;
    logic [RT_W-1:0]  root_in;
    logic [SB_W-1:0]  sb_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[IN_W-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[RT_W-2:0], ge};
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign sb_o    = sb_q[NST-1];

endmodule

>>> design/psd_front.sv
// front stages: magnitudes, face distances, squares and their sum
module psd_front import psd_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [CW-1:0]        point_x_i,
  input  logic [CW-1:0]        point_y_i,
  input  logic [CW-1:0]        point_z_i,
  input  logic [1:0]           shape_i,
  input  logic [CW-2:0]        height_i,
  input  logic [CW-2:0]        box_x_i,
  input  logic [CW-2:0]        box_y_i,
  input  logic [CW-2:0]        box_z_i,
  output logic                 valid_o,
  output logic [2*CW+1:0]      sum_o,
  output logic [1:0]           shape_o,
  output logic [3*(CW+2)-1:0]  faces_o
);

  localparam int OPW = CW + 1;
  localparam int SQW = 2 * CW + 2;
  localparam int FW  = CW + 2;

  logic [CW-1:0]  ax, ay, az;
  logic [FW-1:0]  fx_d, fy_d, fz_d, fh_d;
  logic [OPW-1:0] a_d, b_d, c_d;

  logic           v1_q, v2_q, v3_q;
  logic [OPW-1:0] a_q, b_q, c_q;
  logic [1:0]     sh1_q, sh2_q, sh3_q;
  logic [3*FW-1:0] f1_q, f2_q, f3_q;
  logic [SQW-1:0] pa_q, pb_q, pc_q, sum_q;

  always_comb begin
    ax   = point_x_i[CW-1] ? (CW'(0) - point_x_i) : point_x_i;
    ay   = point_y_i[CW-1] ? (CW'(0) - point_y_i) : point_y_i;
    az   = point_z_i[CW-1] ? (CW'(0) - point_z_i) : point_z_i;
    fx_d = {1'b0, ax, 1'b0} - {3'b000, box_x_i};
    fy_d = {1'b0, ay, 1'b0} - {3'b000, box_y_i};
    fz_d = {1'b0, az, 1'b0} - {3'b000, box_z_i};
    fh_d = {1'b0, az, 1'b0} - {3'b000, height_i};
    case (shape_i)
      SHAPE_SPHERE: begin
        a_d = {1'b0, ax};
        b_d = {1'b0, ay};
        c_d = {1'b0, az};
      end
      SHAPE_CYL: begin
        a_d = {ax, 1'b0};
        b_d = {ay, 1'b0};
        c_d = '0;
      end
      default: begin
        a_d = '0;
        b_d = '0;
        c_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      sh1_q <= shape_i;
      f1_q  <= {fz_d, (shape_i == SHAPE_CYL) ? fh_d : fy_d, fx_d};
      pa_q  <= a_q * a_q;
      pb_q  <= b_q * b_q;
      pc_q  <= c_q * c_q;
      sh2_q <= sh1_q;
      f2_q  <= f1_q;
      sum_q <= pa_q + pb_q + pc_q;
      sh3_q <= sh2_q;
      f3_q  <= f2_q;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign shape_o = sh3_q;
  assign faces_o = f3_q;

endmodule

>>> design/psd_combine.sv
// middle stages: sphere result, positive faces, clamped squares and their sum
module psd_combine import psd_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [CW:0]          root_i,
  input  logic [1:0]           shape_i,
  input  logic [3*(CW+2)-1:0]  faces_i,
  input  logic [CW-2:0]        radius_i,
  output logic                 valid_o,
  output logic [2*CW+1:0]      sum_o,
  output logic [2*CW+5:0]      sb_o
);

  localparam int FW  = CW + 2;
  localparam int SPW = CW + 3;
  localparam int VW  = CW + 1;
  localparam int SQW = 2 * CW + 2;

  logic signed [SPW-1:0] sph_full;
  logic signed [CW-1:0]  sph_d;
  logic signed [FW-1:0]  e0, e1, e2, best_d;
  logic                  p0, p1, p2;
  logic [VW-1:0]         v0_d, v1_d, v2_d;
  logic [1:0]            cnt_d;

  logic                  v1_q, v2_q, v3_q;
  logic [VW-1:0]         v0_q, v1v_q, v2v_q;
  logic [SQW-1:0]        q0_q, q1_q, q2_q, sum_q;
  logic [1:0]            sh1_q, sh2_q, sh3_q;
  logic [CW-1:0]         sp1_q, sp2_q, sp3_q;
  logic [FW-1:0]         b1_q, b2_q, b3_q;
  logic [1:0]            c1_q, c2_q, c3_q;

  always_comb begin
    sph_full = {2'b00, root_i} - {4'b0000, radius_i};
    if (!sph_full[SPW-1] && (|sph_full[SPW-2:CW-1])) begin
      sph_d = {1'b0, {(CW-1){1'b1}}};
    end else begin
      sph_d = sph_full[CW-1:0];
    end
    e0 = (shape_i == SHAPE_CYL) ? ({1'b0, root_i} - {2'b00, radius_i, 1'b0})
                                : faces_i[FW-1:0];
    e1 = faces_i[2*FW-1:FW];
    e2 = faces_i[3*FW-1:2*FW];
    p0 = !e0[FW-1] && (e0 != '0);
    p1 = !e1[FW-1] && (e1 != '0);
    p2 = !e2[FW-1] && (e2 != '0) && (shape_i == SHAPE_BOX);
    v0_d = !p0 ? '0 : (e0[CW] ? {1'b1, {CW{1'b0}}} : e0[CW:0]);
    v1_d = !p1 ? '0 : (e1[CW] ? {1'b1, {CW{1'b0}}} : e1[CW:0]);
    v2_d = !p2 ? '0 : (e2[CW] ? {1'b1, {CW{1'b0}}} : e2[CW:0]);
    best_d = (e1 > e0) ? e1 : e0;
    if ((shape_i == SHAPE_BOX) && (e2 > best_d)) begin
      best_d = e2;
    end
    cnt_d = 2'({1'b0, p0} + {1'b0, p1} + {1'b0, p2});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q  <= v0_d;
      v1v_q <= v1_d;
      v2v_q <= v2_d;
      sh1_q <= shape_i;
      sp1_q <= sph_d;
      b1_q  <= best_d;
      c1_q  <= cnt_d;
      q0_q  <= v0_q * v0_q;
      q1_q  <= v1v_q * v1v_q;
      q2_q  <= v2v_q * v2v_q;
      sh2_q <= sh1_q;
      sp2_q <= sp1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      sum_q <= q0_q + q1_q + q2_q;
      sh3_q <= sh2_q;
      sp3_q <= sp2_q;
      b3_q  <= b2_q;
      c3_q  <= c2_q;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign sb_o    = {sh3_q, sp3_q, b3_q, c3_q};

endmodule

>>> design/primitive_signed_distance_top.sv
// Signed distance from a Q-format point to a centred sphere, box or upright
// cylinder picked by the shape register. Fully pipelined: one point per cycle
// enters unless the output stalls, every stage moves together on a common
// enable, and a one-word skid register at the output takes the last word when
// the consumer stalls, closing the input. Points pass three front stages, a
// bit-serial square root pipeline of COORD_WIDTH+1 stages, three combine
// stages, a second such pipeline and the output stage. Configuration must be
// written only while the pipeline is empty; the block does not enforce this.
module primitive_signed_distance_top import psd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  psd_in_if.sink                 in_s,
  psd_out_if.source              out_m,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-2:0] cfg_wdata_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int FW   = CW + 2;
  localparam int SQW  = 2 * CW + 2;
  localparam int RT_W = CW + 1;
  localparam int SB1W = 2 + 3 * FW;
  localparam int SB2W = 2 + CW + FW + 2;
  localparam logic [CW-2:0] ONE = (CW-1)'(1) << FRAC_BITS;

  logic [1:0]    shape_q;
  logic [CW-2:0] radius_q, height_q, box_x_q, box_y_q, box_z_q;

  logic              en;
  logic              fr_valid, s1_valid, cb_valid, s2_valid;
  logic [SQW-1:0]    fr_sum, cb_sum;
  logic [1:0]        fr_shape;
  logic [3*FW-1:0]   fr_faces;
  logic [RT_W-1:0]   r1, r2;
  logic [SB1W-1:0]   sb1;
  logic [SB2W-1:0]   sb2_in, sb2;

  logic [1:0]        f_shape;
  logic signed [CW-1:0] f_sph;
  logic signed [FW-1:0] f_best, f_half;
  logic [1:0]        f_cnt;
  logic [CW-1:0]     f_root_half;
  logic [CW-1:0]     dist_d;
  logic [1:0]        faces_d;

  logic              fin_valid_q, skid_valid_q;
  logic [CW-1:0]     fin_dist_q, skid_dist_q;
  logic [1:0]        fin_faces_q, skid_faces_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_SPHERE;
      radius_q <= ONE;
      height_q <= ONE;
      box_x_q  <= ONE;
      box_y_q  <= ONE;
      box_z_q  <= ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHAPE:  shape_q  <= cfg_wdata_i[1:0];
        REG_RADIUS: radius_q <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_BOX_X:  box_x_q  <= cfg_wdata_i;
        REG_BOX_Y:  box_y_q  <= cfg_wdata_i;
        REG_BOX_Z:  box_z_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !skid_valid_q;
  assign in_s.ready = en;

  psd_front #(.CW(CW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_s.valid),
    .point_x_i (in_s.point_x),
    .point_y_i (in_s.point_y),
    .point_z_i (in_s.point_z),
    .shape_i   (shape_q),
    .height_i  (height_q),
    .box_x_i   (box_x_q),
    .box_y_i   (box_y_q),
    .box_z_i   (box_z_q),
    .valid_o   (fr_valid),
    .sum_o     (fr_sum),
    .shape_o   (fr_shape),
    .faces_o   (fr_faces)
  );

  psd_sqrt #(.IN_W(SQW), .SB_W(SB1W)) u_sqrt_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_sum),
    .sb_i    ({fr_shape, fr_faces}),
    .valid_o (s1_valid),
    .root_o  (r1),
    .sb_o    (sb1)
  );

  psd_combine #(.CW(CW)) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s1_valid),
    .root_i   (r1),
    .shape_i  (sb1[SB1W-1 -: 2]),
    .faces_i  (sb1[3*FW-1:0]),
    .radius_i (radius_q),
    .valid_o  (cb_valid),
    .sum_o    (cb_sum),
    .sb_o     (sb2_in)
  );

  psd_sqrt #(.IN_W(SQW), .SB_W(SB2W)) u_sqrt_face (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cb_valid),
    .rad_i   (cb_sum),
    .sb_i    (sb2_in),
    .valid_o (s2_valid),
    .root_o  (r2),
    .sb_o    (sb2)
  );

  always_comb begin
    {f_shape, f_sph, f_best, f_cnt} = sb2;
    f_half      = f_best >>> 1;
    f_root_half = r2[RT_W-1:1];
    if (f_root_half[CW-1]) begin
      f_root_half = {1'b0, {(CW-1){1'b1}}};
    end
    case (f_shape) inside
      SHAPE_SPHERE: begin
        dist_d  = f_sph;
        faces_d = (f_sph > 0) ? 2'd1 : 2'd0;
      end
      SHAPE_BOX, SHAPE_CYL: begin
        dist_d  = (f_cnt == 2'd0) ? f_half[CW-1:0] : f_root_half;
        faces_d = f_cnt;
      end
      default: begin
        dist_d  = '0;
        faces_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        fin_valid_q <= s2_valid;
      end
      if (skid_valid_q) begin
        skid_valid_q <= !out_m.ready;
      end else begin
        skid_valid_q <= fin_valid_q && !out_m.ready;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_dist_q  <= dist_d;
      fin_faces_q <= faces_d;
    end
    if (!skid_valid_q) begin
      skid_dist_q  <= fin_dist_q;
      skid_faces_q <= fin_faces_q;
    end
  end

  assign out_m.valid         = skid_valid_q || fin_valid_q;
  assign out_m.distance      = skid_valid_q ? skid_dist_q : fin_dist_q;
  assign out_m.faces_outside = skid_valid_q ? skid_faces_q : fin_faces_q;

endmodule

>>> design/psd_checker.sv
// port-level checks for the signed distance block, bound to the top level
module psd_checker #(
  parameter int CW = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [CW-1:0] distance,
  input logic [1:0]           faces_outside
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("stalled word dropped or changed");

  a_inside_no_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (distance < 0) |-> faces_outside == 2'd0)
    else $error("negative distance with faces outside");

  a_outside_has_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (distance > 0) |-> faces_outside != 2'd0)
    else $error("positive distance with no faces outside");

  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input closed without an output stall");

endmodule

bind primitive_signed_distance_top psd_checker #(.CW(COORD_WIDTH)) u_psd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_s.ready),
  .out_valid     (out_m.valid),
  .out_ready     (out_m.ready),
  .distance      (out_m.distance),
  .faces_outside (out_m.faces_outside)
);

>>> tb/sv/tb_primitive_signed_distance_top.sv
// self-checking testbench for primitive_signed_distance_top with a built-in distance predictor
`timescale 1ns / 1ps

module tb_primitive_signed_distance_top;
  import psd_pkg::*;

  localparam logic [1:0] SHAPE_UNUSED = 2'd3;
  localparam logic [30:0] EXT_MAX = 31'h7fff_ffff;
  localparam logic [30:0] EXT_ONE = 31'd65536;
  localparam longint POS_LIM = 64'sd4294967296;
  localparam longint MAX_DIST = 64'sd2147483647;
  localparam longint MIN_DIST = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 90;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] dval;
    logic [1:0]         faces;
  } dist_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  psd_in_if  in_if ();
  psd_out_if out_if ();

  primitive_signed_distance_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_if),
    .out_m       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [1:0]  shape_q;
  logic [30:0] radius_q, height_q, box_x_q, box_y_q, box_z_q;

  point_t point_q[$];
  dist_t  dist_exp_q[$];
  int unsigned n_points, n_checked, n_phases, errors;
  int unsigned gap_left, burst_left, cyc;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > MAX_DIST) return 32'sh7fff_ffff;
    if (v < MIN_DIST) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint face_dist(longint p, logic [30:0] e);
    longint lo, hi;
    lo = -longint'(e) - 2 * p;
    hi = 2 * p - longint'(e);
    return lo > hi ? lo : hi;
  endfunction

  function automatic dist_t merge_faces(longint m0, longint m1, longint m2, int n);
    longint m[3];
    longint best, v;
    logic [127:0] sum;
    int cnt;
    dist_t res;
    m[0] = m0;
    m[1] = m1;
    m[2] = m2;
    best = m0;
    sum = '0;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (m[i] > best) best = m[i];
      if (m[i] > 0) begin
        v = m[i] > POS_LIM ? POS_LIM : m[i];
        sum = sum + 128'(v) * 128'(v);
        cnt++;
      end
    end
    res.faces = 2'(cnt);
    if (cnt == 0) res.dval = clamp32(best >>> 1);
    else res.dval = clamp32(longint'(isqrt(sum) >> 1));
    return res;
  endfunction

  function automatic dist_t predict_distance(point_t p);
    longint px, py, pz, ax, ay, az, d;
    logic [127:0] s;
    dist_t res;
    px = longint'(p.x);
    py = longint'(p.y);
    pz = longint'(p.z);
    ax = px < 0 ? -px : px;
    ay = py < 0 ? -py : py;
    az = pz < 0 ? -pz : pz;
    res = '0;
    case (shape_q)
      SHAPE_SPHERE: begin
        s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
        res.dval = clamp32(longint'(isqrt(s)) - longint'(radius_q));
        res.faces = res.dval > 0 ? 2'd1 : 2'd0;
      end
      SHAPE_BOX: begin
        res = merge_faces(face_dist(px, box_x_q), face_dist(py, box_y_q),
                          face_dist(pz, box_z_q), 3);
      end
      SHAPE_CYL: begin
        s = 128'(2 * ax) * 128'(2 * ax) + 128'(2 * ay) * 128'(2 * ay);
        d = longint'(isqrt(s)) - 2 * longint'(radius_q);
        res = merge_faces(d, face_dist(pz, height_q), 0, 2);
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // driver: bursts with random gaps, valid held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.point_x <= '0;
      in_if.point_y <= '0;
      in_if.point_z <= '0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        dist_exp_q.insert(dist_exp_q.size(), predict_distance(point_q.pop_front()));
        n_points++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.point_x <= point_q[0].x;
        in_if.point_y <= point_q[0].y;
        in_if.point_z <= point_q[0].z;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    dist_t exp_w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      cyc = 0;
    end else begin
      cyc++;
      if (cyc[9]) out_if.ready <= 1'b1;
      else if (cyc[7]) out_if.ready <= ($urandom_range(0, 4) != 0);
      else out_if.ready <= ($urandom_range(0, 1) != 0);
      if (out_if.valid && out_if.ready) begin
        if (dist_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word dist=%0d faces=%0d", $time,
                   out_if.distance, out_if.faces_outside);
        end else begin
          exp_w = dist_exp_q.pop_front();
          n_checked++;
          if (out_if.distance !== exp_w.dval) begin
            errors++;
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_w.dval, out_if.distance);
          end
          if (out_if.faces_outside !== exp_w.faces) begin
            errors++;
            $display("%0t: faces_outside expected %0d actual %0d", $time,
                     exp_w.faces, out_if.faces_outside);
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [30:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_SHAPE:  shape_q = v[1:0];
      REG_RADIUS: radius_q = v;
      REG_HEIGHT: height_q = v;
      REG_BOX_X:  box_x_q = v;
      REG_BOX_Y:  box_y_q = v;
      REG_BOX_Z:  box_z_q = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
      2: return $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed(32'($urandom_range(0, 1 << 30))) - (1 << 29);
    endcase
  endfunction

  function automatic logic [30:0] rand_extent();
    case ($urandom_range(0, 4))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 1 << 19));
      2: return '0;
      3: return EXT_MAX;
      default: return 31'($urandom_range(0, 1 << 26));
    endcase
  endfunction

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    point_q.insert(point_q.size(), p);
  endtask

  task automatic run_phase(logic [1:0] shape, logic [30:0] r, logic [30:0] h,
                           logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                           int n_rand, bit directed);
    @(posedge clk_i);
    write_reg(REG_SHAPE, 31'(shape));
    write_reg(REG_RADIUS, r);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    cfg_we_i <= 1'b0;
    if (directed) begin
      add_point(0, 0, 0);
      add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      add_point(32'sh8000_0000, 32'sh7fff_ffff, 0);
      add_point(32768, 0, 0);
      add_point(65536, 0, -32768);
      add_point(32768, 32768, 32768);
      add_point(-1, -1, -1);
    end
    for (int i = 0; i < n_rand; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    wait (point_q.size() == 0 && dist_exp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    n_phases++;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SHAPE;
    cfg_wdata_i = '0;
    shape_q = SHAPE_SPHERE;
    radius_q = EXT_ONE;
    height_q = EXT_ONE;
    box_x_q = EXT_ONE;
    box_y_q = EXT_ONE;
    box_z_q = EXT_ONE;
    n_points = 0;
    n_checked = 0;
    n_phases = 0;
    errors = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_phase(SHAPE_SPHERE, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b1);
    run_phase(SHAPE_BOX, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b1);
    run_phase(SHAPE_CYL, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b1);
    run_phase(SHAPE_UNUSED, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 20, 1'b0);
    run_phase(SHAPE_SPHERE, '0, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b0);
    run_phase(SHAPE_SPHERE, EXT_MAX, EXT_ONE, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b0);
    run_phase(SHAPE_BOX, EXT_ONE, EXT_ONE, '0, '0, '0, 40, 1'b0);
    run_phase(SHAPE_BOX, EXT_ONE, EXT_ONE, EXT_MAX, EXT_MAX, EXT_MAX, 40, 1'b0);
    run_phase(SHAPE_CYL, '0, EXT_MAX, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b0);
    run_phase(SHAPE_CYL, EXT_MAX, '0, EXT_ONE, EXT_ONE, EXT_ONE, 40, 1'b0);
    for (int k = 0; k < 6; k++) begin
      run_phase(2'($urandom_range(0, 2)), rand_extent(), rand_extent(), rand_extent(),
                rand_extent(), rand_extent(), 20, 1'b0);
    end

    $display("covered %0d phases over all shapes and register extremes", n_phases);
    $display("points sent %0d, distances checked %0d, errors %0d",
             n_points, n_checked, errors);
    if (errors == 0 && dist_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d distances pending", $time, dist_exp_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
design/psd_pkg.sv
design/psd_if.sv
design/psd_sqrt.sv
design/psd_front.sv
design/psd_combine.sv
design/primitive_signed_distance_top.sv
design/psd_checker.sv
tb/sv/tb_primitive_signed_distance_top.sv
